// File: src/bfu_pkg.sv
// Shared types and constants of the flocking update block.
`default_nettype none

package bfu_pkg;

    localparam int DEF_MAX_AGENTS = 128;

    localparam int CNT_W = 8;
    localparam int DIM_W = 12;
    localparam int Q_W   = 32;
    localparam int DVS_W = 10;

    localparam logic [DVS_W-1:0] DIV_COH = 10'd1000;
    localparam logic [DVS_W-1:0] DIV_ATT = 10'd800;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COUNT  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Division slots, run in this order.
    localparam logic [2:0] SEL_MX   = 3'd0;
    localparam logic [2:0] SEL_MY   = 3'd1;
    localparam logic [2:0] SEL_MVX  = 3'd2;
    localparam logic [2:0] SEL_MVY  = 3'd3;
    localparam logic [2:0] SEL_COHX = 3'd4;
    localparam logic [2:0] SEL_COHY = 3'd5;
    localparam logic [2:0] SEL_ATTX = 3'd6;
    localparam logic [2:0] SEL_ATTY = 3'd7;

    typedef struct packed {
        logic       load_item;
        logic       wr_load;
        logic       res_zero;
        logic       rd_own;
        logic       own_latch;
        logic       wr_clear;
        logic       wr_move;
        logic       sweep_start;
        logic       div_start;
        logic       div_store;
        logic [2:0] div_sel;
        logic       calc_vel;
        logic       calc_pos;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic idx_oob;
        logic opcode;
        logic own_ent;
        logic own_oob;
        logic small_flock;
        logic sweep_busy;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: src/bfu_div.sv
// Sequential signed-by-unsigned divider, two quotient bits per cycle, truncating.
`default_nettype none

module bfu_div
    import bfu_pkg::*;
#(
    parameter int DW = 39
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [DW-1:0]    i_dividend,
    input  wire logic [DVS_W-1:0]        i_divisor,
    output logic                         o_done,
    output logic signed [DW-1:0]         o_quot
);

    localparam int MW    = DW + (DW % 2);
    localparam int STEPS = MW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic             r_neg;
    logic [MW-1:0]    r_acc;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DW-1:0]    w_abs;
    logic [DVS_W:0]   w_t1, w_t2;
    logic             w_ge1, w_ge2;
    logic [DVS_W-1:0] w_rem1, w_rem2;
    logic [MW-1:0]    w_acc1, w_acc2;

    assign w_abs = i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);

    always_comb begin
        w_t1   = {r_rem, r_acc[MW-1]};
        w_ge1  = w_t1 >= {1'b0, r_dvs};
        w_rem1 = w_ge1 ? DVS_W'(w_t1 - {1'b0, r_dvs}) : DVS_W'(w_t1);
        w_acc1 = {r_acc[MW-2:0], w_ge1};
        w_t2   = {w_rem1, w_acc1[MW-1]};
        w_ge2  = w_t2 >= {1'b0, r_dvs};
        w_rem2 = w_ge2 ? DVS_W'(w_t2 - {1'b0, r_dvs}) : DVS_W'(w_t2);
        w_acc2 = {w_acc1[MW-2:0], w_ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= MW'(w_abs);
            r_rem <= '0;
            r_neg <= i_dividend[DW-1];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= w_acc2;
            r_rem <= w_rem2;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_acc[DW-1:0]) : $signed(r_acc[DW-1:0]);

endmodule

`default_nettype wire

// File: src/bfu_ctrl.sv
// Controller state machine sequencing item handling, the table sweep and divisions.
`default_nettype none

module bfu_ctrl
    import bfu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_WRITE    = 4'd2;
    localparam logic [3:0] ST_ZERO     = 4'd3;
    localparam logic [3:0] ST_OWN_RD   = 4'd4;
    localparam logic [3:0] ST_OWN_WAIT = 4'd5;
    localparam logic [3:0] ST_DECIDE   = 4'd6;
    localparam logic [3:0] ST_SWEEP    = 4'd7;
    localparam logic [3:0] ST_DIV_GO   = 4'd8;
    localparam logic [3:0] ST_DIV_WAIT = 4'd9;
    localparam logic [3:0] ST_VEL      = 4'd10;
    localparam logic [3:0] ST_POS      = 4'd11;
    localparam logic [3:0] ST_RESULT   = 4'd12;

    logic [3:0] r_state, n_state;
    logic [2:0] r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.idx_oob) begin
                    n_state = ST_ZERO;
                end else if (!i_status.opcode) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_OWN_RD;
                end
            end
            ST_WRITE: begin
                o_cmd.wr_load = 1'b1;
                n_state = ST_RESULT;
            end
            ST_ZERO: begin
                o_cmd.res_zero = 1'b1;
                n_state = ST_RESULT;
            end
            ST_OWN_RD: begin
                o_cmd.rd_own = 1'b1;
                n_state = ST_OWN_WAIT;
            end
            ST_OWN_WAIT: begin
                o_cmd.own_latch = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.own_ent && !i_status.own_oob) begin
                    o_cmd.wr_clear = 1'b1;
                    n_state = ST_RESULT;
                end else if (i_status.own_ent) begin
                    o_cmd.wr_move = 1'b1;
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.sweep_start = 1'b1;
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (!i_status.sweep_busy) begin
                    // Without a flock only the player attraction needs dividing.
                    n_sel   = i_status.small_flock ? SEL_ATTX : SEL_MX;
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == SEL_ATTY) begin
                        n_state = ST_VEL;
                    end else begin
                        n_sel   = r_sel + 3'd1;
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_VEL: begin
                o_cmd.calc_vel = 1'b1;
                n_state = ST_POS;
            end
            ST_POS: begin
                o_cmd.calc_pos = 1'b1;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= SEL_MX;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: src/bfu_dp.sv
// Datapath: agent table, sweep pipeline, divider, velocity and position arithmetic.
`default_nettype none

module bfu_dp
    import bfu_pkg::*;
#(
    parameter int MAX_AGENTS = DEF_MAX_AGENTS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic                 i_opcode,
    input  wire logic [6:0]           i_entity_index,
    input  wire logic signed [31:0]   i_load_pos_x,
    input  wire logic signed [31:0]   i_load_pos_y,
    input  wire logic signed [31:0]   i_load_vel_x,
    input  wire logic signed [31:0]   i_load_vel_y,
    input  wire logic                 i_load_entering,
    input  wire logic signed [31:0]   i_player_x,
    input  wire logic signed [31:0]   i_player_y,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_new_pos_x,
    output logic signed [31:0]        o_new_pos_y,
    output logic signed [31:0]        o_new_vel_x,
    output logic signed [31:0]        o_new_vel_y,
    output logic                      o_entering_out,
    output logic                      o_saturated
);

    localparam int AW = $clog2(MAX_AGENTS);
    localparam int SW = Q_W + AW;
    localparam int DW = (SW > Q_W + 2) ? SW : Q_W + 2;
    localparam int VW = DW + 4;
    localparam int CXW = AW + 22;
    localparam int EW = 4 * Q_W + 1;

    localparam logic signed [32:0] NEAR_LIM = 33'sd655360;
    localparam logic [40:0]        SQ_LIM   = 41'd429496729600;
    localparam logic signed [VW-1:0] PUSH   = VW'(131072);
    localparam logic signed [VW-1:0] MAXV   = $signed(VW'(32'h7FFFFFFF));
    localparam logic signed [VW-1:0] MINV   = -MAXV - VW'(1);

    function automatic logic [32:0] sat32(input logic signed [VW-1:0] v);
        logic [32:0] res;
        if (v > MAXV) begin
            res = {1'b1, 32'h7FFFFFFF};
        end else if (v < MINV) begin
            res = {1'b1, 32'h80000000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // Configuration.
    logic [CNT_W-1:0] r_count;
    logic [DIM_W-1:0] r_width, r_height;
    logic [CNT_W-1:0] w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_width  <= 12'd800;
            r_height <= 12'd600;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COUNT:  r_count  <= i_cfg_data[CNT_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign w_n = ({3'b0, r_count} > 11'(MAX_AGENTS)) ? CNT_W'(MAX_AGENTS) : r_count;

    // Item registers.
    logic               r_op;
    logic [6:0]         r_idx;
    logic signed [31:0] r_ld_px, r_ld_py, r_ld_vx, r_ld_vy;
    logic               r_ld_ent;
    logic signed [31:0] r_px, r_py;
    logic [AW-1:0]      w_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op     <= i_opcode;
            r_idx    <= i_entity_index;
            r_ld_px  <= i_load_pos_x;
            r_ld_py  <= i_load_pos_y;
            r_ld_vx  <= i_load_vel_x;
            r_ld_vy  <= i_load_vel_y;
            r_ld_ent <= i_load_entering;
            r_px     <= i_player_x;
            r_py     <= i_player_y;
        end
    end

    assign w_a = AW'(r_idx);

    // Agent table: one write and one registered read per cycle.
    logic [EW-1:0]  r_mem [MAX_AGENTS];
    logic [EW-1:0]  r_rd;
    logic           w_we;
    logic [EW-1:0]  w_wd;
    logic [AW-1:0]  w_ra;

    logic [CNT_W-1:0] r_sw_cnt;
    logic             r_sw_act;

    assign w_ra = i_cmd.rd_own ? w_a : AW'(r_sw_cnt);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_a] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    // Own entry.
    logic signed [31:0] r_ox, r_oy, r_ovx, r_ovy;
    logic               r_oent;
    logic signed [32:0] w_wx66, w_hx66;
    logic               w_own_oob;

    always_ff @(posedge i_clk) begin
        if (i_cmd.own_latch) begin
            r_ox   <= r_rd[128:97];
            r_oy   <= r_rd[96:65];
            r_ovx  <= r_rd[64:33];
            r_ovy  <= r_rd[32:1];
            r_oent <= r_rd[0];
        end
    end

    assign w_wx66 = $signed({5'b0, r_width, 16'b0});
    assign w_hx66 = $signed({5'b0, r_height, 16'b0});
    assign w_own_oob = r_ox[31] || (33'(r_ox) > w_wx66) || r_oy[31] || (33'(r_oy) > w_hx66);

    // Sweep pipeline: read, difference, square, accumulate.
    logic r_v1, r_v2, r_v3;
    logic signed [SW-1:0]  r_spx, r_spy, r_svx, r_svy;
    logic signed [CXW-1:0] r_cx, r_cy;
    logic signed [31:0]    w_ex, w_ey, w_evx, w_evy;
    logic signed [32:0]    w_dx, w_dy;
    logic                  w_small;
    logic signed [20:0]    r_s2_dx, r_s2_dy, r_s3_dx, r_s3_dy;
    logic [19:0]           r_s2_ax, r_s2_ay;
    logic                  r_s2_small, r_s3_small;
    logic [39:0]           r_s3_sqx, r_s3_sqy;

    assign w_ex  = r_rd[128:97];
    assign w_ey  = r_rd[96:65];
    assign w_evx = r_rd[64:33];
    assign w_evy = r_rd[32:1];
    assign w_dx  = 33'(w_ex) - 33'(r_ox);
    assign w_dy  = 33'(w_ey) - 33'(r_oy);
    assign w_small = (w_dx < NEAR_LIM) && (w_dx > -NEAR_LIM) &&
                     (w_dy < NEAR_LIM) && (w_dy > -NEAR_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_act <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else begin
            if (i_cmd.sweep_start) begin
                r_sw_act <= (w_n != '0);
            end else if (r_sw_act && ((r_sw_cnt + CNT_W'(1)) == w_n)) begin
                r_sw_act <= 1'b0;
            end
            r_v1 <= r_sw_act;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_sw_cnt <= '0;
            r_spx <= '0;
            r_spy <= '0;
            r_svx <= '0;
            r_svy <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
        end else begin
            if (r_sw_act) begin
                r_sw_cnt <= r_sw_cnt + CNT_W'(1);
            end
            // Entries sitting exactly on the agent do not count as others.
            if (r_v1 && ((w_ex != r_ox) || (w_ey != r_oy))) begin
                r_spx <= r_spx + SW'(w_ex);
                r_spy <= r_spy + SW'(w_ey);
                r_svx <= r_svx + SW'(w_evx);
                r_svy <= r_svy + SW'(w_evy);
            end
            if (r_v3 && r_s3_small && (({1'b0, r_s3_sqx} + {1'b0, r_s3_sqy}) < SQ_LIM)) begin
                r_cx <= r_cx - CXW'(r_s3_dx);
                r_cy <= r_cy - CXW'(r_s3_dy);
            end
        end
        r_s2_dx    <= 21'(w_dx);
        r_s2_dy    <= 21'(w_dy);
        r_s2_ax    <= w_dx[32] ? 20'(-w_dx) : 20'(w_dx);
        r_s2_ay    <= w_dy[32] ? 20'(-w_dy) : 20'(w_dy);
        r_s2_small <= w_small;
        r_s3_dx    <= r_s2_dx;
        r_s3_dy    <= r_s2_dy;
        r_s3_sqx   <= r_s2_ax * r_s2_ax;
        r_s3_sqy   <= r_s2_ay * r_s2_ay;
        r_s3_small <= r_s2_small;
    end

    // Divisions.
    logic signed [DW-1:0] r_mx, r_my, r_mvx, r_mvy, r_cohx, r_cohy, r_attx, r_atty;
    logic signed [DW-1:0] w_dvd, w_quot;
    logic [DVS_W-1:0]     w_dvs, w_nm1;
    logic                 w_div_done;

    assign w_nm1 = DVS_W'(w_n - CNT_W'(1));

    always_comb begin
        w_dvd = '0;
        w_dvs = DIV_ATT;
        case (i_cmd.div_sel)
            SEL_MX:   begin w_dvd = DW'(r_spx); w_dvs = w_nm1; end
            SEL_MY:   begin w_dvd = DW'(r_spy); w_dvs = w_nm1; end
            SEL_MVX:  begin w_dvd = DW'(r_svx); w_dvs = w_nm1; end
            SEL_MVY:  begin w_dvd = DW'(r_svy); w_dvs = w_nm1; end
            SEL_COHX: begin w_dvd = r_mx - DW'(r_ox); w_dvs = DIV_COH; end
            SEL_COHY: begin w_dvd = r_my - DW'(r_oy); w_dvs = DIV_COH; end
            SEL_ATTX: begin w_dvd = DW'(r_px) - DW'(r_ox); w_dvs = DIV_ATT; end
            SEL_ATTY: begin w_dvd = DW'(r_py) - DW'(r_oy); w_dvs = DIV_ATT; end
            default:  ;
        endcase
    end

    bfu_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                SEL_MX:   r_mx   <= w_quot;
                SEL_MY:   r_my   <= w_quot;
                SEL_MVX:  r_mvx  <= w_quot;
                SEL_MVY:  r_mvy  <= w_quot;
                SEL_COHX: r_cohx <= w_quot;
                SEL_COHY: r_cohy <= w_quot;
                SEL_ATTX: r_attx <= w_quot;
                SEL_ATTY: r_atty <= w_quot;
                default:  ;
            endcase
        end
    end

    // Velocity update.
    logic signed [VW-1:0] w_adx, w_ady, w_alx, w_aly, w_pushx, w_pushy;
    logic signed [VW-1:0] w_velx, w_vely;
    logic                 w_flock;
    logic [32:0]          w_satvx, w_satvy;

    assign w_flock = (w_n > CNT_W'(1));
    assign w_adx = VW'(r_mvx) - VW'(r_ovx);
    assign w_ady = VW'(r_mvy) - VW'(r_ovy);
    // Halving truncates toward zero.
    assign w_alx = (w_adx + $signed(VW'(w_adx[VW-1]))) >>> 1;
    assign w_aly = (w_ady + $signed(VW'(w_ady[VW-1]))) >>> 1;
    assign w_pushx = r_ox[31] ? PUSH : ((33'(r_ox) > w_wx66) ? -PUSH : '0);
    assign w_pushy = r_oy[31] ? PUSH : ((33'(r_oy) > w_hx66) ? -PUSH : '0);
    assign w_velx = VW'(r_ovx) + VW'(r_cx) + VW'(r_attx) + w_pushx +
                    (w_flock ? (VW'(r_cohx) + w_alx) : '0);
    assign w_vely = VW'(r_ovy) + VW'(r_cy) + VW'(r_atty) + w_pushy +
                    (w_flock ? (VW'(r_cohy) + w_aly) : '0);
    assign w_satvx = sat32(w_velx);
    assign w_satvy = sat32(w_vely);

    // Result and position.
    logic signed [31:0] r_res_px, r_res_py, r_res_vx, r_res_vy;
    logic               r_res_ent, r_res_sat;
    logic signed [31:0] w_vsx, w_vsy;
    logic [32:0]        w_satpx, w_satpy;

    assign w_vsx = i_cmd.wr_move ? r_ovx : r_res_vx;
    assign w_vsy = i_cmd.wr_move ? r_ovy : r_res_vy;
    assign w_satpx = sat32(VW'(r_ox) + VW'(w_vsx));
    assign w_satpy = sat32(VW'(r_oy) + VW'(w_vsy));

    assign w_we = i_cmd.wr_load | i_cmd.wr_clear | i_cmd.wr_move | i_cmd.calc_pos;

    always_comb begin
        w_wd = {r_ox, r_oy, r_ovx, r_ovy, 1'b0};
        if (i_cmd.wr_load) begin
            w_wd = {r_ld_px, r_ld_py, r_ld_vx, r_ld_vy, r_ld_ent};
        end else if (i_cmd.wr_move) begin
            w_wd = {w_satpx[31:0], w_satpy[31:0], r_ovx, r_ovy, 1'b1};
        end else if (i_cmd.calc_pos) begin
            w_wd = {w_satpx[31:0], w_satpy[31:0], r_res_vx, r_res_vy, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_load) begin
            r_res_px  <= r_ld_px;
            r_res_py  <= r_ld_py;
            r_res_vx  <= r_ld_vx;
            r_res_vy  <= r_ld_vy;
            r_res_ent <= r_ld_ent;
            r_res_sat <= 1'b0;
        end else if (i_cmd.res_zero) begin
            r_res_px  <= '0;
            r_res_py  <= '0;
            r_res_vx  <= '0;
            r_res_vy  <= '0;
            r_res_ent <= 1'b0;
            r_res_sat <= 1'b0;
        end else if (i_cmd.wr_clear) begin
            r_res_px  <= r_ox;
            r_res_py  <= r_oy;
            r_res_vx  <= r_ovx;
            r_res_vy  <= r_ovy;
            r_res_ent <= 1'b0;
            r_res_sat <= 1'b0;
        end else if (i_cmd.wr_move) begin
            r_res_px  <= w_satpx[31:0];
            r_res_py  <= w_satpy[31:0];
            r_res_vx  <= r_ovx;
            r_res_vy  <= r_ovy;
            r_res_ent <= 1'b1;
            r_res_sat <= w_satpx[32] | w_satpy[32];
        end else if (i_cmd.calc_vel) begin
            r_res_vx  <= w_satvx[31:0];
            r_res_vy  <= w_satvy[31:0];
            r_res_ent <= 1'b0;
            r_res_sat <= w_satvx[32] | w_satvy[32];
        end else if (i_cmd.calc_pos) begin
            r_res_px  <= w_satpx[31:0];
            r_res_py  <= w_satpy[31:0];
            r_res_sat <= r_res_sat | w_satpx[32] | w_satpy[32];
        end
    end

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_new_pos_x    <= r_res_px;
            o_new_pos_y    <= r_res_py;
            o_new_vel_x    <= r_res_vx;
            o_new_vel_y    <= r_res_vy;
            o_entering_out <= r_res_ent;
            o_saturated    <= r_res_sat;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status.idx_oob     = (32'(r_idx) >= 32'(MAX_AGENTS));
        o_status.opcode      = r_op;
        o_status.own_ent     = r_oent;
        o_status.own_oob     = w_own_oob;
        o_status.small_flock = !w_flock;
        o_status.sweep_busy  = r_sw_act | r_v1 | r_v2 | r_v3;
        o_status.div_done    = w_div_done;
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

// File: src/boids_flock_update.sv
// Flocking update block: top level joining the controller and the datapath.
// The block keeps a table of agents and takes one item at a time. A flocking update reads
// its own entry, sweeps the first count entries through the single table read port at one
// entry per cycle, then runs eight divisions (two when count is 1 or less) on one shared
// divider. A finished result waits in an output register, and the next item is taken once
// the result is handed over to it.
`default_nettype none

module boids_flock_update
    import bfu_pkg::*;
#(
    parameter int MAX_AGENTS = DEF_MAX_AGENTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [DIM_W-1:0]   i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_opcode,
    input  wire logic [6:0]         i_entity_index,
    input  wire logic signed [31:0] i_load_pos_x,
    input  wire logic signed [31:0] i_load_pos_y,
    input  wire logic signed [31:0] i_load_vel_x,
    input  wire logic signed [31:0] i_load_vel_y,
    input  wire logic               i_load_entering,
    input  wire logic signed [31:0] i_player_x,
    input  wire logic signed [31:0] i_player_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_new_pos_x,
    output logic signed [31:0]      o_new_pos_y,
    output logic signed [31:0]      o_new_vel_x,
    output logic signed [31:0]      o_new_vel_y,
    output logic                    o_entering_out,
    output logic                    o_saturated
);

    t_cmd    w_cmd;
    t_status w_status;

    bfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bfu_dp #(.MAX_AGENTS(MAX_AGENTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_entity_index  (i_entity_index),
        .i_load_pos_x    (i_load_pos_x),
        .i_load_pos_y    (i_load_pos_y),
        .i_load_vel_x    (i_load_vel_x),
        .i_load_vel_y    (i_load_vel_y),
        .i_load_entering (i_load_entering),
        .i_player_x      (i_player_x),
        .i_player_y      (i_player_y),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_new_pos_x     (o_new_pos_x),
        .o_new_pos_y     (o_new_pos_y),
        .o_new_vel_x     (o_new_vel_x),
        .o_new_vel_y     (o_new_vel_y),
        .o_entering_out  (o_entering_out),
        .o_saturated     (o_saturated)
    );

    // A new item is never accepted while the sweep pipeline still holds entries.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !w_status.sweep_busy)
        else $error("item accepted during table sweep");

    // A result is only moved into the output register when that register is free.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_status.out_free)
        else $error("output register overwritten");

    // At most one source writes the agent table in a cycle.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.wr_load, w_cmd.wr_clear, w_cmd.wr_move, w_cmd.calc_pos}))
        else $error("conflicting table writes");

endmodule

`default_nettype wire
